/* hdl/rid_pkg.sv */
// Shared types, opcodes and the sequencer microcode for the restoring divider.
// No dependencies; used by rid_datapath and restoring_integer_divider.
package rid_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_UQUO = 2'd0;
    localparam op_t OP_UREM = 2'd1;
    localparam op_t OP_SQUO = 2'd2;
    localparam op_t OP_SREM = 2'd3;

    localparam int PC_W = 2;
    typedef logic [PC_W-1:0] pc_t;

    // Step addresses of the program
    localparam pc_t PC_LOAD   = 2'd0;
    localparam pc_t PC_MAG    = 2'd1;
    localparam pc_t PC_DIV    = 2'd2;
    localparam pc_t PC_FINISH = 2'd3;

    // Jump taken when the condition holds, else fall through to pc + 1 (wraps)
    typedef enum logic [1:0]
    {
        JMP_NEVER,
        JMP_NO_IN,
        JMP_CNT_NZ,
        JMP_OUT_BUSY
    } jump_t;

    typedef struct packed
    {
        logic  load;
        logic  magnitude;
        logic  div_step;
        logic  finish;
        jump_t jump;
        pc_t   target;
    } ctrl_t;

    typedef struct packed
    {
        logic cnt_nz;
    } status_t;

    function automatic ctrl_t ucode(pc_t pc);
        ctrl_t w;
        w = '0;
        unique case (pc)
            PC_LOAD:
            begin
                w.load   = 1'b1;
                w.jump   = JMP_NO_IN;
                w.target = PC_LOAD;
            end
            PC_MAG:
            begin
                w.magnitude = 1'b1;
                w.jump      = JMP_NEVER;
                w.target    = PC_LOAD;
            end
            PC_DIV:
            begin
                w.div_step = 1'b1;
                w.jump     = JMP_CNT_NZ;
                w.target   = PC_DIV;
            end
            PC_FINISH:
            begin
                w.finish = 1'b1;
                w.jump   = JMP_OUT_BUSY;
                w.target = PC_FINISH;
            end
            default:
            begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

/* hdl/rid_datapath.sv */
// Operand, remainder and quotient registers with the shared compare/subtract.
// Driven by one rid_pkg::ctrl_t word per cycle from the sequencer.
module rid_datapath
    import rid_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  ctrl_t            ctrl,
    input  logic             in_valid,
    input  op_t              op,
    input  logic [WIDTH-1:0] numerator,
    input  logic [WIDTH-1:0] denominator,
    output status_t          status,
    output logic [WIDTH-1:0] answer
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] ZERO     = {WIDTH{1'b0}};

    op_t              op_reg;
    logic [WIDTH-1:0] num_reg;   // numerator bits shift out, quotient bits shift in
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;
    logic             ovf_reg;
    logic             dz_reg;

    logic             is_signed;
    logic             nneg;
    logic             dneg;
    logic [WIDTH-1:0] shifted;
    logic             fits;
    logic [WIDTH-1:0] quo_fix;
    logic [WIDTH-1:0] rem_fix;

    assign is_signed = (op_reg == OP_SQUO) || (op_reg == OP_SREM);
    assign nneg      = is_signed && num_reg[WIDTH-1];
    assign dneg      = is_signed && den_reg[WIDTH-1];

    // A set top bit means the shifted remainder already exceeds any divisor
    assign shifted = {rem_reg[WIDTH-2:0], num_reg[WIDTH-1]};
    assign fits    = rem_reg[WIDTH-1] || (shifted >= den_reg);

    always_comb
    begin
        if (ovf_reg)
        begin
            quo_fix = ALL_ONES;
            rem_fix = ZERO;
        end
        else
        begin
            // divide by zero leaves the numerator magnitude in the remainder
            quo_fix = dz_reg ? ZERO : (neg_q_reg ? ZERO - num_reg : num_reg);
            rem_fix = neg_r_reg ? ZERO - rem_reg : rem_reg;
        end
    end

    assign answer = ((op_reg == OP_UREM) || (op_reg == OP_SREM)) ? rem_fix : quo_fix;
    assign status.cnt_nz = (cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load && in_valid)
        begin
            op_reg  <= op;
            num_reg <= numerator;
            den_reg <= denominator;
        end
        else if (ctrl.magnitude)
        begin
            num_reg   <= nneg ? ZERO - num_reg : num_reg;
            den_reg   <= dneg ? ZERO - den_reg : den_reg;
            rem_reg   <= ZERO;
            cnt_reg   <= CNT_W'(WIDTH - 1);
            neg_q_reg <= nneg ^ dneg;
            neg_r_reg <= nneg;
            ovf_reg   <= is_signed && (num_reg == MOST_NEG) && (den_reg == ALL_ONES);
            dz_reg    <= (den_reg == ZERO);
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= fits ? shifted - den_reg : shifted;
            num_reg <= {num_reg[WIDTH-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/restoring_integer_divider.sv */
// Top level of the restoring divider: microcode sequencer, output register.
// Depends on rid_pkg and rid_datapath.
//
//  channel  | dir | tdata fields (low bit up)                      | tuser
//  s_axis   | in  | op[1:0], numerator[W-1:0], denominator[W-1:0]  | -
//  m_axis   | out | answer[W-1:0]                                  | -
//
// A word passes through accept, a magnitude step, WIDTH divide steps
// (one quotient bit per cycle through the shared compare/subtract) and a
// sign-fix step that writes the output register. One word in flight; a held
// result stalls the sign-fix step until taken. Reset is asynchronous, active
// low, and returns the sequencer to the load step with the output empty.
module restoring_integer_divider
    import rid_pkg::*;
#(
    parameter int WIDTH = 32,
    localparam int IN_W  = ((2 + 2 * WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // op, numerator, denominator
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // answer
);

    pc_t              pc_reg;
    pc_t              pc_next;
    ctrl_t            ctrl;
    status_t          status;
    logic             take;
    logic             out_busy;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] answer;
    logic             accept;

    assign ctrl          = ucode(pc_reg);
    assign s_axis_tready = ctrl.load;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;

    always_comb
    begin
        unique case (ctrl.jump)
            JMP_NEVER:    take = 1'b0;
            JMP_NO_IN:    take = !s_axis_tvalid;
            JMP_CNT_NZ:   take = status.cnt_nz;
            JMP_OUT_BUSY: take = out_busy;
            default:      take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (ctrl.finish && !out_busy)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish && !out_busy)
        begin
            out_data_reg <= answer;
        end
    end

    rid_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk         (clk),
        .ctrl        (ctrl),
        .in_valid    (s_axis_tvalid),
        .op          (s_axis_tdata[1:0]),
        .numerator   (s_axis_tdata[WIDTH+1:2]),
        .denominator (s_axis_tdata[2*WIDTH+1:WIDTH+2]),
        .status      (status),
        .answer      (answer)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    // accepted word moves the sequencer straight to the magnitude step
    a_accept_to_mag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pc_reg == PC_MAG))
        else $error("sequencer did not advance after accept");

    // only one word in flight
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a new result appears only from the sign-fix step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ctrl.finish))
        else $error("result valid without finish step");

    // divide loop leaves only when the bit counter is spent
    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.div_step && status.cnt_nz) |=> ctrl.div_step)
        else $error("divide loop exited early");

endmodule
